### hw/rtl/bsm_pkg.sv
`default_nettype none

package bsm_pkg;

  // item sequence through the pipe
  localparam int unsigned ROOT_BITS   = 33;
  localparam int unsigned QUOT_BITS   = 33;
  localparam int unsigned SQRT_FIRST  = 3;
  localparam int unsigned DECIDE_ST   = SQRT_FIRST + ROOT_BITS;
  localparam int unsigned MULT_ST     = DECIDE_ST + 1;
  localparam int unsigned PROD_ST     = MULT_ST + 1;
  localparam int unsigned DIV_FIRST   = PROD_ST + 1;
  localparam int unsigned OUT_ST      = DIV_FIRST + QUOT_BITS;
  localparam int unsigned NUM_STAGES  = OUT_ST + 1;

  localparam logic [1:0] CASE_MERGED = 2'd0;
  localparam logic [1:0] CASE_FIRST  = 2'd1;
  localparam logic [1:0] CASE_SECOND = 2'd2;

  localparam logic [30:0] RADIUS_MAX = '1;

  typedef struct packed {
    logic [2:0][31:0] c1;
    logic [2:0][31:0] c2;
    logic [30:0]      r1;
    logic [30:0]      r2;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [2:0][63:0] sq;
    logic [67:0]      rem;
    logic [32:0]      root;
    logic [34:0]      rad2;
    logic [33:0]      fac;
    logic [1:0]       code;
    logic [2:0][48:0] plo;
    logic [2:0][48:0] phi;
    logic [2:0][67:0] drem;
    logic [2:0][32:0] quo;
    logic [2:0][31:0] res;
    logic [30:0]      rad;
    logic             sat;
  } item_t;

endpackage

`default_nettype wire

### hw/rtl/bsm_if.sv
`default_nettype none

interface bsm_pair_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic [30:0]        first_radius;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;
  logic [30:0]        second_radius;

  modport source (output valid, first_x, first_y, first_z, first_radius,
                  second_x, second_y, second_z, second_radius, input ready);
  modport sink (input valid, first_x, first_y, first_z, first_radius,
                second_x, second_y, second_z, second_radius, output ready);
endinterface

interface bsm_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [30:0]        out_radius;
  logic [1:0]         case_taken;
  logic               saturated;

  modport source (output valid, out_x, out_y, out_z, out_radius, case_taken,
                  saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_radius, case_taken,
                saturated, output ready);
endinterface

`default_nettype wire

### hw/rtl/bounding_sphere_merge_unit.sv
`default_nettype none

// channel  | dir | handshake     | payload
// ---------+-----+---------------+------------------------------------------
// pair     | in  | valid / ready | first_x/y/z, first_radius, second_x/y/z,
//          |     |               | second_radius
// merged   | out | valid / ready | out_x/y/z, out_radius, case_taken, saturated
//
// one item enters per cycle unless the pipe is stalled; each item passes
// through the stages (1 diff, 1 square, 1 sum, 33 root bits, 1 decide,
// 1 multiply, 1 product, 33 quotient bits, 1 output register)
// the whole pipe advances together whenever the output register is empty or
// its item is taken, so a stall freezes every stage in place
// synchronous reset clears only the per-stage valid bits

module bounding_sphere_merge_unit (
  input  wire logic     clk,
  input  wire logic     rst,
  bsm_pair_if.sink      pair,
  bsm_result_if.source  merged
);

  localparam int unsigned LAST = bsm_pkg::NUM_STAGES - 1;

  bsm_pkg::item_t pipe [0:LAST];
  bsm_pkg::item_t nxt  [0:LAST];
  logic           vld  [0:LAST];
  logic           adv;

  // global advance: output slot free or being drained
  assign adv        = ~vld[LAST] | merged.ready;
  assign pair.ready = adv;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LAST; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= pair.valid;
      for (int i = 1; i <= LAST; i++) vld[i] <= vld[i-1];
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= LAST; i++) pipe[i] <= nxt[i];
    end
  end

  // stage 0: center differences and their magnitudes
  always_comb begin
    logic signed [32:0] d [0:2];
    nxt[0]           = pipe[0];
    nxt[0].c1        = {pair.first_z, pair.first_y, pair.first_x};
    nxt[0].c2        = {pair.second_z, pair.second_y, pair.second_x};
    nxt[0].r1        = pair.first_radius;
    nxt[0].r2        = pair.second_radius;
    d[0] = {pair.second_x[31], pair.second_x} - {pair.first_x[31], pair.first_x};
    d[1] = {pair.second_y[31], pair.second_y} - {pair.first_y[31], pair.first_y};
    d[2] = {pair.second_z[31], pair.second_z} - {pair.first_z[31], pair.first_z};
    for (int k = 0; k < 3; k++) begin
      nxt[0].neg[k] = d[k][32];
      nxt[0].mag[k] = d[k][32] ? 32'(-d[k]) : d[k][31:0];
    end
  end

  // stage 1: squares
  always_comb begin
    nxt[1] = pipe[0];
    for (int k = 0; k < 3; k++) nxt[1].sq[k] = pipe[0].mag[k] * pipe[0].mag[k];
  end

  // stage 2: squared distance, root starts empty
  always_comb begin
    nxt[2]      = pipe[1];
    nxt[2].rem  = {4'b0, pipe[1].sq[0]} + {4'b0, pipe[1].sq[1]}
                + {4'b0, pipe[1].sq[2]};
    nxt[2].root = '0;
  end

  // integer square root, one result bit per stage, msb first
  for (genvar j = 0; j < bsm_pkg::ROOT_BITS; j++) begin : g_sqrt
    localparam int unsigned S = bsm_pkg::SQRT_FIRST + j;
    localparam int unsigned B = bsm_pkg::ROOT_BITS - 1 - j;
    always_comb begin
      logic [67:0] t;
      nxt[S] = pipe[S-1];
      t = ({35'b0, pipe[S-1].root} << (B + 1)) | (68'd1 << (2 * B));
      if (t <= pipe[S-1].rem) begin
        nxt[S].rem     = pipe[S-1].rem - t;
        nxt[S].root[B] = 1'b1;
      end
    end
  end

  // decide which sphere wins, doubled radius and center scale factor
  always_comb begin
    logic [34:0] rad2;
    logic [34:0] two_r1;
    logic [34:0] two_r2;
    localparam int unsigned S = bsm_pkg::DECIDE_ST;
    nxt[S] = pipe[S-1];
    rad2   = {4'b0, pipe[S-1].r1} + {4'b0, pipe[S-1].r2} + {2'b0, pipe[S-1].root};
    two_r1 = {3'b0, pipe[S-1].r1, 1'b0};
    two_r2 = {3'b0, pipe[S-1].r2, 1'b0};
    nxt[S].rad2 = rad2;
    nxt[S].fac  = 34'(rad2 - two_r1);
    if (rad2 < two_r1) begin
      nxt[S].code = bsm_pkg::CASE_FIRST;
    end else if (rad2 < two_r2) begin
      nxt[S].code = bsm_pkg::CASE_SECOND;
    end else if (pipe[S-1].root == '0) begin
      // coincident centers, equal radii
      nxt[S].code = bsm_pkg::CASE_FIRST;
    end else begin
      nxt[S].code = bsm_pkg::CASE_MERGED;
    end
  end

  // split multiply of magnitude by factor
  always_comb begin
    localparam int unsigned S = bsm_pkg::MULT_ST;
    nxt[S] = pipe[S-1];
    for (int k = 0; k < 3; k++) begin
      nxt[S].plo[k] = {17'b0, pipe[S-1].mag[k]} * {32'b0, pipe[S-1].fac[16:0]};
      nxt[S].phi[k] = {17'b0, pipe[S-1].mag[k]} * {32'b0, pipe[S-1].fac[33:17]};
    end
  end

  // full product plus half divisor for rounding
  always_comb begin
    localparam int unsigned S = bsm_pkg::PROD_ST;
    nxt[S] = pipe[S-1];
    for (int k = 0; k < 3; k++) begin
      nxt[S].drem[k] = {19'b0, pipe[S-1].plo[k]} + ({19'b0, pipe[S-1].phi[k]} << 17)
                     + {35'b0, pipe[S-1].root};
      nxt[S].quo[k]  = '0;
    end
  end

  // restoring divide by twice the distance, one quotient bit per stage
  for (genvar j = 0; j < bsm_pkg::QUOT_BITS; j++) begin : g_div
    localparam int unsigned S = bsm_pkg::DIV_FIRST + j;
    localparam int unsigned B = bsm_pkg::QUOT_BITS - 1 - j;
    always_comb begin
      logic [67:0] t;
      nxt[S] = pipe[S-1];
      t = {34'b0, pipe[S-1].root, 1'b0} << B;
      for (int k = 0; k < 3; k++) begin
        if (t <= pipe[S-1].drem[k]) begin
          nxt[S].drem[k]   = pipe[S-1].drem[k] - t;
          nxt[S].quo[k][B] = 1'b1;
        end
      end
    end
  end

  // output register: pick the sphere, saturate the merged radius
  always_comb begin
    localparam int unsigned S = bsm_pkg::OUT_ST;
    nxt[S]     = pipe[S-1];
    nxt[S].sat = 1'b0;
    case (pipe[S-1].code)
      bsm_pkg::CASE_MERGED: begin
        for (int k = 0; k < 3; k++) begin
          nxt[S].res[k] = pipe[S-1].neg[k] ? pipe[S-1].c1[k] - pipe[S-1].quo[k][31:0]
                                           : pipe[S-1].c1[k] + pipe[S-1].quo[k][31:0];
        end
        if (pipe[S-1].rad2[34:32] != 3'b0) begin
          nxt[S].rad = bsm_pkg::RADIUS_MAX;
          nxt[S].sat = 1'b1;
        end else begin
          nxt[S].rad = pipe[S-1].rad2[31:1];
        end
      end
      bsm_pkg::CASE_SECOND: begin
        nxt[S].res = pipe[S-1].c2;
        nxt[S].rad = pipe[S-1].r2;
      end
      default: begin
        nxt[S].res = pipe[S-1].c1;
        nxt[S].rad = pipe[S-1].r1;
      end
    endcase
  end

  assign merged.valid      = vld[LAST];
  assign merged.out_x      = pipe[LAST].res[0];
  assign merged.out_y      = pipe[LAST].res[1];
  assign merged.out_z      = pipe[LAST].res[2];
  assign merged.out_radius = pipe[LAST].rad;
  assign merged.case_taken = pipe[LAST].code;
  assign merged.saturated  = pipe[LAST].sat;

endmodule

`default_nettype wire
